[rtl/mjtb_pkg.sv]
// Package for the minimum-jerk time base generator.
// Holds the widths, fixed-point constants, register indexes and stage side-band types.
// No dependencies.
package mjtb_pkg;

  // Tick width and derived datapath widths.
  localparam int TICK_WIDTH = 24;
  localparam int STEP_W     = 24;
  localparam int TIME_W     = 32;
  localparam int RAMP_W     = TICK_WIDTH + STEP_W;
  localparam int XW         = ((RAMP_W > 33) ? RAMP_W : 33) + 1;
  localparam int CMP_W      = ((TICK_WIDTH > 24) ? TICK_WIDTH : 24) + 1;
  localparam int CUT_W      = 25;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_W  = ((TICK_WIDTH + 1 + 7) / 8) * 8;
  localparam int OUT_W = 56;

  // Divider step counts.
  localparam int ZDIV_STEPS = 30;
  localparam int GDIV_STEPS = 31;

  // Fixed-point constants.
  localparam logic signed [33:0] Z_ONE         = 34'sd1073741824;
  localparam logic signed [33:0] Z_TWO         = 34'sd2147483648;
  localparam logic signed [39:0] P_TEN         = 40'sd10737418240;
  localparam logic [16:0]        SHAPE_MAX     = 17'd131071;
  localparam logic [31:0]        GAMMA_POS_LIM = 32'h7FFF_FFFF;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_STEP     = 3'd0,
    REG_START_TIME    = 3'd1,
    REG_DURATION      = 3'd2,
    REG_ALPHA         = 3'd3,
    REG_GAMMA_OFFSET  = 3'd4,
    REG_OFFSET_CUTOFF = 3'd5
  } cfg_reg_e;

  // Side-band that travels with the normalised-time divider.
  typedef struct packed {
    logic off_en;
    logic inwin;
    logic neg;
    logic clamp_pos;
    logic clamp_neg;
  } zside_t;

  // Side-band that travels with the gamma divider.
  typedef struct packed {
    logic        off_en;
    logic        inwin;
    logic        ovf;
    logic        sh_sat;
    logic [16:0] shape;
  } gside_t;

endpackage

[rtl/min_jerk_time_base_gamma_unit.sv]
// Minimum-jerk time base generator, top level and complete datapath.
// Depends on mjtb_pkg for widths, constants and side-band types.
//
// Usage:
//   Input beats arrive on the s_axis channel: tdata holds the tick count in
//   the low bits and the add_offset request just above it. Each beat yields
//   exactly one result beat on m_axis carrying gamma (Q15.16), shape_rate
//   (Q1.16) and the saturated flag.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i and must
//   only change while no beat is in flight.
//   The pipeline is 74 registers deep. One beat can be accepted every cycle
//   while the result register holds no untaken beat; the depth is set by the
//   two restoring dividers, one quotient bit per stage (30 stages for the
//   normalised time, 31 for gamma), plus the multiplier stages between them.
//   Reset clears all valid bits and loads the register defaults; no clearing
//   pass is needed.
//   The whole pipeline advances together: while the result register holds a
//   beat the receiver has not taken, every stage holds and s_axis_tready is
//   low, so nothing is lost or repeated.
module min_jerk_time_base_gamma_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [mjtb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mjtb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: tick, add_offset, zero padding
  input  logic [mjtb_pkg::IN_W-1:0]          s_axis_tdata,
  // Output stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: gamma [31:0], shape_rate [48:32], saturated [49], zero padding
  output logic [mjtb_pkg::OUT_W-1:0]         m_axis_tdata
);

  localparam int ZN = mjtb_pkg::ZDIV_STEPS;
  localparam int GN = mjtb_pkg::GDIV_STEPS;
  localparam int RW = mjtb_pkg::RAMP_W;
  localparam int XW = mjtb_pkg::XW;
  localparam int TW = mjtb_pkg::TICK_WIDTH;

  // Configuration registers.
  logic [23:0] ramp_step_q;
  logic [31:0] start_q;
  logic [31:0] dur_q;
  logic [31:0] alpha_q;
  logic [31:0] offset_q;
  logic [mjtb_pkg::CUT_W-1:0] cutoff_q;
  logic [31:0] dur_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_step_q <= 24'd16777;
      start_q     <= 32'd50331;
      dur_q       <= 32'd16777216;
      alpha_q     <= 32'd1073752561;
      offset_q    <= 32'd0;
      cutoff_q    <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mjtb_pkg::REG_RAMP_STEP:     ramp_step_q <= cfg_data_i[23:0];
        mjtb_pkg::REG_START_TIME:    start_q     <= cfg_data_i;
        mjtb_pkg::REG_DURATION:      dur_q       <= cfg_data_i;
        mjtb_pkg::REG_ALPHA:         alpha_q     <= cfg_data_i;
        mjtb_pkg::REG_GAMMA_OFFSET:  offset_q    <= cfg_data_i;
        mjtb_pkg::REG_OFFSET_CUTOFF: cutoff_q    <= cfg_data_i[mjtb_pkg::CUT_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero duration counts as one LSB.
  assign dur_eff = (dur_q == 32'd0) ? 32'd1 : dur_q;

  // Global advance: the pipeline moves unless the result register is stuck.
  logic out_v_q;
  logic en;
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: ramp time and offset qualification.
  logic [TW-1:0] tick;
  logic          add_req;
  logic          v1_q, off1_q;
  logic [RW-1:0] ramp1_q;
  assign tick    = s_axis_tdata[TW-1:0];
  assign add_req = s_axis_tdata[TW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ramp1_q <= RW'(tick) * RW'(ramp_step_q);
      off1_q  <= add_req && !cutoff_q[mjtb_pkg::CUT_W-1] &&
                 (mjtb_pkg::CMP_W'(tick) <=
                  mjtb_pkg::CMP_W'(cutoff_q[mjtb_pkg::CUT_W-2:0]));
    end
  end

  // Stage 2: distance from the window start and window test.
  logic          v2_q, off2_q, ge2_q, inwin2_q;
  logic [XW-1:0] d2_q;
  logic [XW-1:0] rx, sx, ex;
  assign rx = XW'(ramp1_q);
  assign sx = XW'(start_q);
  assign ex = sx + XW'(dur_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      off2_q   <= off1_q;
      ge2_q    <= rx >= sx;
      inwin2_q <= (rx >= sx) && (rx < ex);
      d2_q     <= (rx >= sx) ? rx - sx : sx - rx;
    end
  end

  // Stage 3 (divider entry): clamp detection and top quotient bit.
  logic                    zv_q   [0:ZN];
  mjtb_pkg::zside_t        zs_q   [0:ZN];
  logic [32:0]             zr_q   [0:ZN];
  logic [30:0]             zq_q   [0:ZN];
  logic [XW-1:0]           dx, dur2x;
  logic                    zbit;
  assign dx    = XW'(dur_eff);
  assign dur2x = dx << 1;
  assign zbit  = d2_q >= dx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) zv_q[0] <= 1'b0;
    else if (en) zv_q[0] <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      zs_q[0].off_en    <= off2_q;
      zs_q[0].inwin     <= inwin2_q;
      zs_q[0].neg       <= !ge2_q;
      zs_q[0].clamp_pos <= ge2_q && (d2_q >= dur2x);
      zs_q[0].clamp_neg <= !ge2_q && zbit;
      zr_q[0]           <= zbit ? 33'(d2_q - dx) : 33'(d2_q);
      zq_q[0]           <= {30'd0, zbit};
    end
  end

  // Normalised-time divider: one quotient bit per stage.
  for (genvar k = 1; k <= ZN; k++) begin : g_zdiv
    logic [33:0] r2;
    logic        b;
    assign r2 = {zr_q[k-1], 1'b0};
    assign b  = r2 >= {2'b00, dur_eff};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) zv_q[k] <= 1'b0;
      else if (en) zv_q[k] <= zv_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        zs_q[k] <= zs_q[k-1];
        zr_q[k] <= b ? 33'(r2 - {2'b00, dur_eff}) : 33'(r2);
        zq_q[k] <= {zq_q[k-1][29:0], b};
      end
    end
  end

  // Stage Z: signed normalised time z and z - 1.
  logic               vz_q, offz_q, inwz_q;
  logic signed [33:0] z_d, zz_q, zm1_q;
  always_comb begin
    if (zs_q[ZN].clamp_pos) z_d = mjtb_pkg::Z_TWO;
    else if (zs_q[ZN].clamp_neg) z_d = -mjtb_pkg::Z_ONE;
    else if (zs_q[ZN].neg) z_d = -$signed({3'b000, zq_q[ZN]});
    else z_d = $signed({3'b000, zq_q[ZN]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vz_q <= 1'b0;
    else if (en) vz_q <= zv_q[ZN];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      offz_q <= zs_q[ZN].off_en;
      inwz_q <= zs_q[ZN].inwin;
      zz_q   <= z_d;
      zm1_q  <= z_d - mjtb_pkg::Z_ONE;
    end
  end

  // Stage B: magnitude products |z|*|z-1| and |z|^2.
  logic               vb_q, offb_q, inwb_q;
  logic signed [33:0] zb_q;
  logic [31:0]        azb_q;
  logic [63:0]        pw_q, pzz_q;
  logic [33:0]        az, azm1;
  assign az   = zz_q[33] ? 34'(-zz_q) : 34'(zz_q);
  assign azm1 = zm1_q[33] ? 34'(-zm1_q) : 34'(zm1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (en) vb_q <= vz_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      offb_q <= offz_q;
      inwb_q <= inwz_q;
      zb_q   <= zz_q;
      azb_q  <= az[31:0];
      pw_q   <= az[31:0] * azm1[31:0];
      pzz_q  <= az[31:0] * az[31:0];
    end
  end

  // Stage C: truncate to Q2.30, |w| and z^2.
  logic               vc_q, offc_q, inwc_q;
  logic signed [33:0] zc_q;
  logic [31:0]        azc_q, wm_q;
  logic [32:0]        z2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (en) vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      offc_q <= offb_q;
      inwc_q <= inwb_q;
      zc_q   <= zb_q;
      azc_q  <= azb_q;
      wm_q   <= pw_q[61:30];
      z2_q   <= pzz_q[62:30];
    end
  end

  // Stage D: w^2, z^2 * |z| and the quadratic factor 6z^2 - 15z + 10.
  logic               vd_q, offd_q, inwd_q;
  logic [63:0]        ww_q, z3p_q;
  logic signed [39:0] p_q;
  logic signed [39:0] pz2, pz;
  assign pz2 = $signed({7'd0, z2_q});
  assign pz  = 40'(zc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else if (en) vd_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      offd_q <= offc_q;
      inwd_q <= inwc_q;
      ww_q   <= wm_q * wm_q;
      z3p_q  <= z2_q[31:0] * azc_q;
      p_q    <= (pz2 <<< 2) + (pz2 <<< 1) - ((pz <<< 4) - pz) + mjtb_pkg::P_TEN;
    end
  end

  // Stage E: csidot = 30 w^2 and z^3 (only needed inside the window).
  logic               ve_q, offe_q, inwe_q;
  logic [38:0]        c_e_q;
  logic [30:0]        z3_q;
  logic [33:0]        pe_q;
  logic [38:0]        wwt;
  assign wwt = 39'(ww_q[63:30]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ve_q <= 1'b0;
    else if (en) ve_q <= vd_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      offe_q <= offd_q;
      inwe_q <= inwd_q;
      c_e_q  <= (wwt << 5) - (wwt << 1);
      z3_q   <= z3p_q[60:30];
      pe_q   <= p_q[33:0];
    end
  end

  // Stage F: csi = z^3 * p and the saturated shape rate.
  logic        vf_q, offf_q, inwf_q, shsatf_q;
  logic [38:0] c_f_q;
  logic [33:0] csi_q;
  logic [16:0] shapef_q;
  logic [64:0] csip;
  logic [24:0] shraw;
  assign csip  = 65'(z3_q) * 65'(pe_q);
  assign shraw = c_e_q[38:14];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else if (en) vf_q <= ve_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      offf_q   <= offe_q;
      inwf_q   <= inwe_q;
      c_f_q    <= c_e_q;
      csi_q    <= csip[63:30];
      shsatf_q <= shraw > 25'(mjtb_pkg::SHAPE_MAX);
      shapef_q <= (shraw > 25'(mjtb_pkg::SHAPE_MAX)) ? mjtb_pkg::SHAPE_MAX : shraw[16:0];
    end
  end

  // Stage G: alpha - csi, at least one LSB.
  logic               vg_q, offg_q, inwg_q, shsatg_q;
  logic [38:0]        c_g_q;
  logic [16:0]        shapeg_q;
  logic [31:0]        diff_q;
  logic signed [35:0] diff;
  assign diff = $signed({4'd0, alpha_q}) - $signed({2'd0, csi_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vg_q <= 1'b0;
    else if (en) vg_q <= vf_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      offg_q   <= offf_q;
      inwg_q   <= inwf_q;
      shsatg_q <= shsatf_q;
      shapeg_q <= shapef_q;
      c_g_q    <= c_f_q;
      diff_q   <= (diff < 36'sd1) ? 32'd1 : diff[31:0];
    end
  end

  // Stage H: divisor m = duration * (alpha - csi).
  logic        vh_q, offh_q, inwh_q, shsath_q;
  logic [38:0] c_h_q;
  logic [16:0] shapeh_q;
  logic [63:0] m_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vh_q <= 1'b0;
    else if (en) vh_q <= vg_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      offh_q   <= offg_q;
      inwh_q   <= inwg_q;
      shsath_q <= shsatg_q;
      shapeh_q <= shapeg_q;
      c_h_q    <= c_g_q;
      m_h_q    <= dur_eff * diff_q;
    end
  end

  // Stage I (divider entry): overflow test c * 2^9 >= m and first remainder.
  logic             gv_q [0:GN];
  mjtb_pkg::gside_t gs_q [0:GN];
  logic [63:0]      gm_q [0:GN];
  logic [63:0]      gr_q [0:GN];
  logic [30:0]      gq_q [0:GN];
  logic [63:0]      cx;
  assign cx = 64'(c_h_q) << 9;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gv_q[0] <= 1'b0;
    else if (en) gv_q[0] <= vh_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      gs_q[0].off_en <= offh_q;
      gs_q[0].inwin  <= inwh_q;
      gs_q[0].ovf    <= cx >= m_h_q;
      gs_q[0].sh_sat <= shsath_q;
      gs_q[0].shape  <= shapeh_q;
      gm_q[0]        <= m_h_q;
      gr_q[0]        <= cx;
      gq_q[0]        <= '0;
    end
  end

  // Gamma divider: one quotient bit per stage.
  for (genvar k = 1; k <= GN; k++) begin : g_gdiv
    logic [64:0] r2;
    logic        b;
    assign r2 = {gr_q[k-1], 1'b0};
    assign b  = r2 >= {1'b0, gm_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) gv_q[k] <= 1'b0;
      else if (en) gv_q[k] <= gv_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        gs_q[k] <= gs_q[k-1];
        gm_q[k] <= gm_q[k-1];
        gr_q[k] <= b ? 64'(r2 - {1'b0, gm_q[k-1]}) : 64'(r2);
        gq_q[k] <= {gq_q[k-1][29:0], b};
      end
    end
  end

  // Result register: window select, offset addition and final clip.
  logic [31:0]        g0;
  logic signed [33:0] gsum;
  logic [31:0]        gamma_d, gamma_q;
  logic               sat_d, sat_q;
  logic [16:0]        shape_q;

  always_comb begin
    if (!gs_q[GN].inwin) g0 = 32'd0;
    else if (gs_q[GN].ovf) g0 = mjtb_pkg::GAMMA_POS_LIM;
    else g0 = {1'b0, gq_q[GN]};
    gsum = $signed({2'b00, g0});
    if (gs_q[GN].off_en) gsum = gsum + 34'(signed'(offset_q));
    sat_d = gs_q[GN].sh_sat || (gs_q[GN].inwin && gs_q[GN].ovf);
    if (gsum > 34'sd2147483647) begin
      gamma_d = mjtb_pkg::GAMMA_POS_LIM;
      sat_d   = 1'b1;
    end else if (gsum < -34'sd2147483648) begin
      gamma_d = 32'h8000_0000;
      sat_d   = 1'b1;
    end else begin
      gamma_d = gsum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= gv_q[GN];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      gamma_q <= gamma_d;
      shape_q <= gs_q[GN].shape;
      sat_q   <= sat_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'd0, sat_q, shape_q, gamma_q};

  // A held result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // No beat enters while the result register is blocked.
  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted during stall");

  // A sample inside the window is never clamped in normalised time.
  a_win_no_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (zv_q[0] && zs_q[0].inwin) |-> (!zs_q[0].clamp_pos && !zs_q[0].clamp_neg))
    else $error("window sample was clamped");

  // The normalised-time remainder ends below the divisor.
  a_zdiv_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (zv_q[ZN] && !zs_q[ZN].clamp_pos && !zs_q[ZN].clamp_neg) |->
    (zr_q[ZN] < {1'b0, dur_eff}))
    else $error("z divider remainder out of range");

  // The gamma remainder ends below the divisor when no overflow was flagged.
  a_gdiv_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gv_q[GN] && !gs_q[GN].ovf) |-> (gr_q[GN] < gm_q[GN]))
    else $error("gamma divider remainder out of range");

endmodule
